// ===== sv/button_gesture_classifier_top_defines.svh =====
// Assertion macros shared by the gesture classifier RTL.
`ifndef BUTTON_GESTURE_CLASSIFIER_TOP_DEFINES_SVH
`define BUTTON_GESTURE_CLASSIFIER_TOP_DEFINES_SVH

// Condition must hold at every edge outside reset.
`define BGC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication outside reset.
`define BGC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/bgc_pkg.sv =====
// Shared types and constants for the button gesture classifier.
`default_nettype none

package bgc_pkg;

  localparam int unsigned CntW  = 16;
  localparam int unsigned RelW  = 8;
  localparam int unsigned IdxW  = 2;

  localparam logic [CntW-1:0] LongPressReset   = 16'd200;
  localparam logic [CntW-1:0] ClickWindowReset = 16'd40;
  localparam logic [CntW-1:0] PopupReset       = 16'd150;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_LOCK   = 2'd1,
    CMD_UNLOCK = 2'd2,
    CMD_ALARM  = 2'd3
  } cmd_t;

  typedef enum logic [IdxW-1:0] {
    REG_LONG_PRESS   = 2'd0,
    REG_CLICK_WINDOW = 2'd1,
    REG_POPUP        = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CntW-1:0] long_press_ticks;
    logic [CntW-1:0] click_window_ticks;
    logic [CntW-1:0] popup_ticks;
  } cfg_t;

  typedef struct packed {
    cmd_t command;
    cmd_t popup_code;
  } res_t;

  function automatic logic [CntW-1:0] sat_inc16(input logic [CntW-1:0] v);
    sat_inc16 = (v == {CntW{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== sv/button_gesture_classifier_top.sv =====
// A request accepted into the input register (s1) is classified as it moves into the result register.
// Throughput: one request per cycle; the input and result registers advance whenever the result
// register is free, so ready only drops while the result register is held and the input register is full.
// Reset (rst, synchronous, active high): thresholds return to 200/40/150 ticks,
// all gesture counters, flags and the popup clear, both pipeline stages empty.
// Top level of the button gesture classifier.
`default_nettype none

`include "button_gesture_classifier_top_defines.svh"

module button_gesture_classifier_top (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire logic [bgc_pkg::IdxW-1:0] wr_index,
  input  wire logic [bgc_pkg::CntW-1:0] wr_data,
  input  wire logic                     in_valid,
  output      logic                     in_ready,
  input  wire logic                     pressed,
  output      logic                     out_valid,
  input  wire logic                     out_ready,
  output      logic [1:0]               command,
  output      logic [1:0]               popup_code
);

  bgc_pkg::cfg_t cfg;
  bgc_pkg::res_t res;
  bgc_pkg::res_t res_reg;

  logic s1_valid;
  logic s1_pressed;
  logic advance;
  logic out_free;
  logic fresh_cmd;

  bgc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_pressed <= pressed;
    end
  end

  bgc_gesture u_gesture (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .pressed (s1_pressed),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_reg <= res;
    end
  end

  assign command    = res_reg.command;
  assign popup_code = res_reg.popup_code;

  assign fresh_cmd = out_valid && res_reg.command != bgc_pkg::CMD_NONE;

  // a fresh command always shows as the popup on the same tick
  `BGC_ASSERT_IMPLY(a_cmd_popup, fresh_cmd, popup_code == command, "command missing from popup")

endmodule

`default_nettype wire

// ===== sv/bgc_cfg_regs.sv =====
// Configuration register file for the gesture thresholds.
`default_nettype none

module bgc_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic [bgc_pkg::IdxW-1:0]   wr_index,
  input  wire logic [bgc_pkg::CntW-1:0]   wr_data,
  output bgc_pkg::cfg_t                   cfg
);

  bgc_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.long_press_ticks   <= bgc_pkg::LongPressReset;
      regs.click_window_ticks <= bgc_pkg::ClickWindowReset;
      regs.popup_ticks        <= bgc_pkg::PopupReset;
    end else if (wr_en) begin
      // unknown index is dropped
      unique case (wr_index)
        bgc_pkg::REG_LONG_PRESS:   regs.long_press_ticks   <= wr_data;
        bgc_pkg::REG_CLICK_WINDOW: regs.click_window_ticks <= wr_data;
        bgc_pkg::REG_POPUP:        regs.popup_ticks        <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// ===== sv/bgc_gesture.sv =====
// Gesture state registers and per-tick classification logic.
`default_nettype none

`include "button_gesture_classifier_top_defines.svh"

module bgc_gesture (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic          pressed,
  input  wire bgc_pkg::cfg_t cfg,
  output bgc_pkg::res_t      res
);

  logic                       held_flag,     held_flag_next;
  logic [bgc_pkg::CntW-1:0]   hold_count,    hold_count_next;
  logic                       long_fired,    long_fired_next;
  logic [bgc_pkg::RelW-1:0]   release_count, release_count_next;
  logic [bgc_pkg::CntW-1:0]   window_count,  window_count_next;
  bgc_pkg::cmd_t              popup_message, popup_message_next;
  logic [bgc_pkg::CntW-1:0]   popup_age,     popup_age_next;
  bgc_pkg::cmd_t              cmd;

  always_comb begin
    logic [bgc_pkg::CntW-1:0] hold_inc;
    logic [bgc_pkg::CntW-1:0] win_inc;

    cmd                = bgc_pkg::CMD_NONE;
    held_flag_next     = held_flag;
    hold_count_next    = hold_count;
    long_fired_next    = long_fired;
    release_count_next = release_count;
    window_count_next  = window_count;
    popup_message_next = popup_message;
    popup_age_next     = popup_age;

    // popup ages before anything else this tick
    if (popup_message != bgc_pkg::CMD_NONE) begin
      popup_age_next = bgc_pkg::sat_inc16(popup_age);
    end

    hold_inc = bgc_pkg::sat_inc16(held_flag ? hold_count : '0);
    if (pressed) begin
      held_flag_next  = 1'b1;
      hold_count_next = hold_inc;
      if (hold_inc >= cfg.long_press_ticks && !long_fired) begin
        cmd                = bgc_pkg::CMD_ALARM;
        long_fired_next    = 1'b1;
        release_count_next = '0;
        window_count_next  = '0;
      end
    end else begin
      if (held_flag) begin
        if (!long_fired) begin
          if (release_count != {bgc_pkg::RelW{1'b1}}) begin
            release_count_next = release_count + 1'b1;
          end
          window_count_next = '0;
        end else begin
          long_fired_next    = 1'b0;
          release_count_next = '0;
          window_count_next  = '0;
        end
      end
      held_flag_next  = 1'b0;
      hold_count_next = '0;
    end

    // click window keeps running even through a new press
    win_inc = bgc_pkg::sat_inc16(window_count_next);
    if (release_count_next != '0) begin
      window_count_next = win_inc;
      if (win_inc >= cfg.click_window_ticks) begin
        cmd = (release_count_next == {{(bgc_pkg::RelW-1){1'b0}}, 1'b1}) ?
              bgc_pkg::CMD_LOCK : bgc_pkg::CMD_UNLOCK;
        release_count_next = '0;
        window_count_next  = '0;
      end
    end

    if (cmd != bgc_pkg::CMD_NONE) begin
      popup_message_next = cmd;
      popup_age_next     = '0;
    end

    if (popup_message_next != bgc_pkg::CMD_NONE && popup_age_next > cfg.popup_ticks) begin
      popup_message_next = bgc_pkg::CMD_NONE;
      popup_age_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_flag     <= 1'b0;
      hold_count    <= '0;
      long_fired    <= 1'b0;
      release_count <= '0;
      window_count  <= '0;
      popup_message <= bgc_pkg::CMD_NONE;
      popup_age     <= '0;
    end else if (step) begin
      held_flag     <= held_flag_next;
      hold_count    <= hold_count_next;
      long_fired    <= long_fired_next;
      release_count <= release_count_next;
      window_count  <= window_count_next;
      popup_message <= popup_message_next;
      popup_age     <= popup_age_next;
    end
  end

  assign res.command    = cmd;
  assign res.popup_code = popup_message_next;

  `BGC_ASSERT_IMPLY(a_age_idle, popup_message == bgc_pkg::CMD_NONE, popup_age == '0, "stale age")
  `BGC_ASSERT_IMPLY(a_fired_held, long_fired, held_flag, "long press flagged while released")
  `BGC_ASSERT_IMPLY(a_fired_no_clicks, long_fired, release_count == '0, "clicks after alarm")

endmodule

`default_nettype wire
